FILE: design/bdac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdac_pkg;

   localparam int VALUE_WIDTH     = 64;
   localparam int SIGNED_WIDTH    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   // decimal digits of 2^VALUE_WIDTH - 1: floor(w * log10(2)) + 1
   localparam int NUM_DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH       = 4 * NUM_DIGITS;
   localparam int BIT_CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_WIDTH   = $clog2(NUM_DIGITS + 1);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_IDX_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   typedef struct packed {
      logic                   neg;
      logic [VALUE_WIDTH-1:0] mag;
   } item_type;

endpackage

`default_nettype wire

FILE: design/bdac_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bdac_front (
   input  wire logic [63:0]        req_value,
   input  wire logic               req_mode,
   output bdac_pkg::item_type      item
);
   import bdac_pkg::*;

   logic [SIGNED_WIDTH-1:0] raw;
   logic [SIGNED_WIDTH-1:0] raw_mag;
   logic                    neg;

   always_comb begin
      raw     = req_value[SIGNED_WIDTH-1:0];
      neg     = req_mode & raw[SIGNED_WIDTH-1];
      // most negative value negates to itself, which reads as 2^(w-1) unsigned
      raw_mag = neg ? (~raw + SIGNED_WIDTH'(1)) : raw;
      item.neg = neg;
      if (req_mode) begin
         item.mag = VALUE_WIDTH'(raw_mag);
      end else begin
         item.mag = req_value[VALUE_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: design/bdac_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bdac_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_valid,
   output logic                    wr_ready,
   input  wire bdac_pkg::item_type wr_item,
   output logic                    rd_valid,
   input  wire logic               rd_ready,
   output bdac_pkg::item_type      rd_item
);
   import bdac_pkg::*;

   item_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                       push, pop;

   always_comb begin
      wr_ready = (cnt_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
      rd_valid = (cnt_ff != '0);
      rd_item  = mem_ff[rd_ptr_ff];
      push     = wr_valid & wr_ready;
      pop      = rd_valid & rd_ready;
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_IDX_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_IDX_WIDTH'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_WIDTH'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

FILE: design/bdac_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bdac_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire bdac_pkg::item_type in_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_character,
   output logic                    rsp_last
);
   import bdac_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_TRIM = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   shift_ff, shift_in;
   logic [BCD_WIDTH-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_WIDTH-1:0] bitcnt_ff, bitcnt_in;
   logic [DIG_CNT_WIDTH-1:0] digcnt_ff, digcnt_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [BCD_WIDTH-1:0]     bcd_adj;
   logic [3:0]               top_digit;
   logic [3:0]               dig;
   logic                     slot_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         dig = bcd_ff[4*i +: 4];
         if (dig inside {[4'd5:4'd15]}) begin
            bcd_adj[4*i +: 4] = dig + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = dig;
         end
      end
   end

   always_comb begin
      top_digit    = bcd_ff[BCD_WIDTH-1 -: 4];
      slot_free    = !rsp_valid_ff || rsp_ready;
      in_ready     = (state_ff == ST_IDLE);
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      bitcnt_in    = bitcnt_ff;
      digcnt_in    = digcnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               shift_in  = in_item.mag;
               neg_in    = in_item.neg;
               bcd_in    = '0;
               bitcnt_in = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in    = {bcd_adj[BCD_WIDTH-2:0], shift_ff[VALUE_WIDTH-1]};
            shift_in  = shift_ff << 1;
            bitcnt_in = bitcnt_ff - BIT_CNT_WIDTH'(1);
            if (bitcnt_ff == '0) begin
               digcnt_in = DIG_CNT_WIDTH'(NUM_DIGITS);
               state_in  = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (top_digit == 4'd0 && digcnt_ff != DIG_CNT_WIDTH'(1)) begin
               bcd_in    = bcd_ff << 4;
               digcnt_in = digcnt_ff - DIG_CNT_WIDTH'(1);
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + {4'd0, top_digit};
               rsp_last_in  = (digcnt_ff == DIG_CNT_WIDTH'(1));
               bcd_in       = bcd_ff << 4;
               digcnt_in    = digcnt_ff - DIG_CNT_WIDTH'(1);
               if (digcnt_ff == DIG_CNT_WIDTH'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
      bitcnt_ff   <= bitcnt_in;
      digcnt_ff   <= digcnt_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

FILE: design/binary_to_decimal_ascii_unit.sv
// Path from an accepted number's beat to its first character:
// 1 queue-to-load, 64 shift-add-3 steps, 1 to 20 trim steps, 1 output register.
// Sequencing: the converter holds one number through its shift, trim and emit
// steps and takes no new one until done; the 2-entry queue takes numbers while it works.
// Reset: synchronous, active high; clears queue, sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_value,
   input  wire logic        req_mode,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_character,
   output logic             rsp_last
);
   import bdac_pkg::*;

   item_type front_item;
   item_type back_item;
   logic     back_valid;
   logic     back_ready;

   bdac_front u_front (
      .req_value (req_value),
      .req_mode  (req_mode),
      .item      (front_item)
   );

   bdac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_item  (front_item),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_item  (back_item)
   );

   bdac_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (back_valid),
      .in_ready      (back_ready),
      .in_item       (back_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_binary_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_unit;
   import bdac_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 600;
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } char_beat_type;

   class decimal_text_scoreboard;
      char_beat_type expected_chars[$];
      int numbers;
      int signed_numbers;
      int negatives;
      int characters;
      int longest;
      int errors;

      function new();
         numbers = 0;
         signed_numbers = 0;
         negatives = 0;
         characters = 0;
         longest = 0;
         errors = 0;
      endfunction

      // decimal text of one accepted number, most significant digit first
      function void note_number(logic [63:0] value, logic mode);
         logic [63:0]   mag;
         logic [63:0]   raw;
         logic [63:0]   lane_mask;
         logic [63:0]   sign_bit;
         logic          negative;
         logic [3:0]    digit_list[$];
         char_beat_type beat;
         int            text_len;
         negative = 1'b0;
         if (mode) begin
            lane_mask = (SIGNED_WIDTH >= 64) ? '1 : ((64'd1 << SIGNED_WIDTH) - 64'd1);
            raw = value & lane_mask;
            sign_bit = 64'd1 << (SIGNED_WIDTH - 1);
            if ((raw & sign_bit) != 0) begin
               negative = 1'b1;
               mag = (~raw + 64'd1) & lane_mask;
               if (mag == 0) mag = sign_bit;
            end else begin
               mag = raw;
            end
            signed_numbers++;
         end else begin
            lane_mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
            mag = value & lane_mask;
         end
         do begin
            digit_list.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
         end while (mag != 0);
         text_len = digit_list.size();
         if (negative) begin
            beat.character = ASCII_MINUS;
            beat.last = 1'b0;
            expected_chars.push_back(beat);
            negatives++;
            text_len++;
         end
         foreach (digit_list[i]) begin
            beat.character = ASCII_ZERO + 8'(digit_list[i]);
            beat.last = (i == digit_list.size() - 1);
            expected_chars.push_back(beat);
         end
         if (text_len > longest) longest = text_len;
         numbers++;
      endfunction

      function void check_character(logic [7:0] character, logic last);
         char_beat_type want;
         characters++;
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, character 0x%02h last %0b", $time, character,
                     last);
            return;
         end
         want = expected_chars.pop_front();
         if (character !== want.character) begin
            errors++;
            $display("%0t: character mismatch, expected 0x%02h actual 0x%02h", $time,
                     want.character, character);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %0b actual %0b", $time, want.last, last);
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value = '0;
   logic        req_mode = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   decimal_text_scoreboard text_board = new();

   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   longint cycle_count = 0;

   binary_to_decimal_ascii_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_mode      (req_mode),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d characters outstanding", $time,
                  cycle_count, text_board.pending());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) text_board.check_character(rsp_character, rsp_last);
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   task automatic send_number(input logic [63:0] value, input logic mode);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= {$urandom, $urandom};
         req_mode <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_mode <= mode;
      do @(posedge clock); while (!req_ready);
      text_board.note_number(value, mode);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (text_board.pending() != 0) @(posedge clock);
   endtask

   function automatic void pick_random_number(output logic [63:0] value, output logic mode);
      int          kind;
      logic [63:0] power;
      logic [31:0] low;
      kind = $urandom_range(0, 9);
      mode = 1'b0;
      if (kind <= 4) begin
         value = {$urandom, $urandom} >> $urandom_range(0, 63);
      end else if (kind == 5) begin
         power = 64'd1;
         repeat ($urandom_range(0, 19)) power = power * 64'd10;
         value = power - 64'($urandom_range(0, 1));
      end else if (kind <= 8) begin
         low = $urandom >> $urandom_range(0, 31);
         if ($urandom_range(0, 1)) low = -low;
         value = {$urandom, low};
         mode = 1'b1;
      end else begin
         case ($urandom_range(0, 3))
            0: low = 32'h8000_0000;
            1: low = 32'h7FFF_FFFF;
            2: low = 32'hFFFF_FFFF;
            default: low = 32'h0000_0000;
         endcase
         value = {$urandom, low};
         mode = 1'b1;
      end
   endfunction

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      logic [63:0] value;
      logic        mode;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) begin
         pick_random_number(value, mode);
         send_number(value, mode);
      end
      wait_for_drain();
   endtask

   initial begin
      logic [63:0] value;
      logic        mode;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, field extremes, 20-digit values, most negative int
      send_number(64'd0, 1'b0);
      send_number(64'd0, 1'b1);
      send_number(64'd1, 1'b0);
      send_number(64'd9, 1'b0);
      send_number(64'd10, 1'b0);
      send_number(64'd100, 1'b0);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_number(64'd10000000000000000000, 1'b0);
      send_number(64'd9999999999999999999, 1'b0);
      send_number(64'h8000_0000_0000_0000, 1'b0);
      send_number(64'h5555_5555_5555_5555, 1'b0);
      send_number(64'h0000_0000_FFFF_FFFF, 1'b0);
      send_number(64'h0000_0000_8000_0000, 1'b1);
      send_number(64'h0000_0000_7FFF_FFFF, 1'b1);
      send_number(64'h0000_0000_FFFF_FFFF, 1'b1);
      send_number(64'hFFFF_FFFF_0000_0000, 1'b1);
      send_number(64'hAAAA_AAAA_8000_0001, 1'b1);
      send_number(64'h0000_0000_FFFF_FFF6, 1'b1);
      send_number(64'hFFFF_FFFF_0000_3039, 1'b1);
      wait_for_drain();

      run_phase(50, 0, 0);
      run_phase(50, 73, 0);
      run_phase(50, 0, 73);
      run_phase(50, 35, 35);

      // long receiver hold-off while the sender keeps offering beats
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 1'b1;
      repeat (12) begin
         pick_random_number(value, mode);
         send_number(value, mode);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d numbers (%0d signed, %0d negative) into %0d characters,",
               text_board.numbers, text_board.signed_numbers, text_board.negatives,
               text_board.characters);
      $display("longest text %0d characters, under sender gaps, receiver stalls and a hold-off.",
               text_board.longest);
      if (text_board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
